// ----- hw/rtl/drfe_pkg.sv -----
// ----------------------------------------------------------------------------
// drfe_pkg
// Shared types and constants for the DHCP reply filter and extractor.
// ----------------------------------------------------------------------------
package drfe_pkg;

    localparam int MAX_FRAME         = 2048;
    localparam int LINK_HEADER_BYTES = 42;
    localparam int OFF_W             = $clog2(MAX_FRAME + 1);

    // BOOTP field offsets relative to the start of the BOOTP message
    localparam int BP_OP       = 0;
    localparam int BP_YIADDR   = 16;
    localparam int BP_CHADDR   = 28;
    localparam int BP_COOKIE   = 236;
    localparam int BP_OPTIONS  = 240;
    localparam int BP_MSG_TYPE = 242;

    localparam logic [7:0] OP_REPLY      = 8'd2;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_END       = 8'd255;

    localparam logic [7:0] COOKIE [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_TYPE = 1'd1;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_OP,
        CLS_YIADDR,
        CLS_MAC,
        CLS_COOKIE,
        CLS_TYPE,
        CLS_OPT
    } byte_cls_t;

    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_SKIP,
        PH_CAPTURE
    } walk_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        byte_cls_t  cls;
        logic [2:0] idx;
    } ent_t;

    typedef struct packed {
        logic [47:0] own_mac;
        logic [3:0]  expected_type;
    } cfg_t;

endpackage

// ----- hw/rtl/drfe_front.sv -----
// ----------------------------------------------------------------------------
// drfe_front
// Counts frame offset and tags each byte with the BOOTP field it belongs to.
// ----------------------------------------------------------------------------
module drfe_front
    import drfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] frame_byte,
    input  logic       frame_end,
    input  logic       q_full,
    output logic       q_push,
    output ent_t       q_ent
);

    localparam logic [OFF_W-1:0] OFF_MAX    = OFF_W'(MAX_FRAME);
    localparam logic [OFF_W-1:0] OFF_OP     = OFF_W'(LINK_HEADER_BYTES + BP_OP);
    localparam logic [OFF_W-1:0] OFF_YI     = OFF_W'(LINK_HEADER_BYTES + BP_YIADDR);
    localparam logic [OFF_W-1:0] OFF_CH     = OFF_W'(LINK_HEADER_BYTES + BP_CHADDR);
    localparam logic [OFF_W-1:0] OFF_CK     = OFF_W'(LINK_HEADER_BYTES + BP_COOKIE);
    localparam logic [OFF_W-1:0] OFF_OPTS   = OFF_W'(LINK_HEADER_BYTES + BP_OPTIONS);
    localparam logic [OFF_W-1:0] OFF_TYPE   = OFF_W'(LINK_HEADER_BYTES + BP_MSG_TYPE);

    logic [OFF_W-1:0] off_reg;
    logic [OFF_W-1:0] off_next;
    logic [OFF_W-1:0] rel;
    byte_cls_t        cls;
    logic [2:0]       idx;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        cls = CLS_NONE;
        idx = '0;
        rel = '0;
        if (off_reg < OFF_MAX)
        begin
            if (off_reg == OFF_OP)
            begin
                cls = CLS_OP;
            end
            else if (off_reg >= OFF_YI && off_reg < OFF_YI + OFF_W'(4))
            begin
                cls = CLS_YIADDR;
            end
            else if (off_reg >= OFF_CH && off_reg < OFF_CH + OFF_W'(6))
            begin
                cls = CLS_MAC;
                rel = off_reg - OFF_CH;
                idx = rel[2:0];
            end
            else if (off_reg >= OFF_CK && off_reg < OFF_CK + OFF_W'(4))
            begin
                cls = CLS_COOKIE;
                rel = off_reg - OFF_CK;
                idx = rel[2:0];
            end
            else if (off_reg == OFF_TYPE)
            begin
                cls = CLS_TYPE;
            end
            else if (off_reg >= OFF_OPTS)
            begin
                cls = CLS_OPT;
            end
        end
    end

    always_comb
    begin
        off_next = off_reg;
        if (q_push)
        begin
            if (frame_end)
            begin
                off_next = '0;
            end
            else if (off_reg < OFF_MAX)
            begin
                off_next = off_reg + OFF_W'(1);
            end
        end
    end

    assign q_ent = '{data: frame_byte, last: frame_end, cls: cls, idx: idx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
        end
        else
        begin
            off_reg <= off_next;
        end
    end

endmodule

// ----- hw/rtl/drfe_fifo.sv -----
// ----------------------------------------------------------------------------
// drfe_fifo
// Short queue of tagged bytes between the classifier and the checker.
// ----------------------------------------------------------------------------
module drfe_fifo
    import drfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  ent_t push_ent,
    output logic full,
    input  logic pop,
    output logic valid,
    output ent_t head
);

    ent_t               ent_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg;
    logic [FIFO_AW-1:0] wp_next;
    logic [FIFO_AW-1:0] rp_reg;
    logic [FIFO_AW-1:0] rp_next;
    logic [FIFO_AW:0]   cnt_reg;
    logic [FIFO_AW:0]   cnt_next;

    assign full  = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = ent_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + FIFO_AW'(1) : wp_reg;
        rp_next  = pop  ? rp_reg + FIFO_AW'(1) : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (FIFO_AW+1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= push_ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/drfe_back.sv -----
// ----------------------------------------------------------------------------
// drfe_back
// Checks tagged bytes, walks the DHCP options and holds the result.
// ----------------------------------------------------------------------------
module drfe_back
    import drfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  ent_t        q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic        server_found,
    output logic [31:0] server_addr,
    output logic [31:0] offered_addr
);

    walk_phase_t phase_reg;
    walk_phase_t phase_next;
    logic        match_reg;
    logic        match_next;
    logic        typ_reg;
    logic        typ_next;
    logic [7:0]  skip_reg;
    logic [7:0]  skip_next;
    logic [2:0]  cap_reg;
    logic [2:0]  cap_next;
    logic [31:0] srv_sh_reg;
    logic [31:0] srv_sh_next;
    logic [31:0] off_sh_reg;
    logic [31:0] off_sh_next;
    logic        seen_reg;
    logic        seen_next;
    logic        done_reg;
    logic        done_next;
    logic [31:0] lease_srv_reg;
    logic [31:0] lease_srv_next;
    logic [31:0] lease_off_reg;
    logic [31:0] lease_off_next;
    logic        ov_reg;
    logic        ov_next;
    logic        acc_reg;
    logic        acc_next;
    logic        fnd_reg;
    logic        fnd_next;
    logic [7:0]  mac_byte;
    logic [7:0]  b;
    logic        walk;

    assign q_pop = q_valid && (!q_head.last || !ov_reg || out_ready);
    assign b     = q_head.data;

    always_comb
    begin
        case (q_head.idx)
            3'd0:    mac_byte = cfg.own_mac[47:40];
            3'd1:    mac_byte = cfg.own_mac[39:32];
            3'd2:    mac_byte = cfg.own_mac[31:24];
            3'd3:    mac_byte = cfg.own_mac[23:16];
            3'd4:    mac_byte = cfg.own_mac[15:8];
            default: mac_byte = cfg.own_mac[7:0];
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        match_next     = match_reg;
        typ_next       = typ_reg;
        skip_next      = skip_reg;
        cap_next       = cap_reg;
        srv_sh_next    = srv_sh_reg;
        off_sh_next    = off_sh_reg;
        seen_next      = seen_reg;
        done_next      = done_reg;
        lease_srv_next = lease_srv_reg;
        lease_off_next = lease_off_reg;
        acc_next       = acc_reg;
        fnd_next       = fnd_reg;
        ov_next        = ov_reg && !out_ready;
        walk           = 1'b0;

        if (q_pop)
        begin
            unique case (q_head.cls)
                CLS_OP:
                begin
                    if (b != OP_REPLY)
                    begin
                        match_next = 1'b0;
                    end
                end
                CLS_YIADDR:
                begin
                    off_sh_next = {off_sh_reg[23:0], b};
                end
                CLS_MAC:
                begin
                    if (b != mac_byte)
                    begin
                        match_next = 1'b0;
                    end
                end
                CLS_COOKIE:
                begin
                    if (b != COOKIE[q_head.idx[1:0]])
                    begin
                        match_next = 1'b0;
                    end
                end
                CLS_TYPE:
                begin
                    typ_next = 1'b1;
                    walk     = !done_reg;
                    if (b != {4'd0, cfg.expected_type})
                    begin
                        match_next = 1'b0;
                    end
                end
                CLS_OPT:
                begin
                    walk = !done_reg;
                end
                default:
                begin
                end
            endcase

            if (walk)
            begin
                unique case (phase_reg)
                    PH_CODE:
                    begin
                        if (b == OPT_END)
                        begin
                            done_next = 1'b1;
                        end
                        else if (b == OPT_SERVER_ID)
                        begin
                            phase_next = PH_CAPTURE;
                            cap_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        skip_next  = b;
                        phase_next = (b == 8'd0) ? PH_CODE : PH_SKIP;
                    end
                    PH_SKIP:
                    begin
                        skip_next = skip_reg - 8'd1;
                        if (skip_reg == 8'd1)
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                    PH_CAPTURE:
                    begin
                        if (cap_reg != 3'd0)
                        begin
                            srv_sh_next = {srv_sh_reg[23:0], b};
                        end
                        cap_next = cap_reg + 3'd1;
                        if (cap_reg == 3'd4)
                        begin
                            seen_next = 1'b1;
                            done_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (q_head.last)
            begin
                acc_next = match_next && typ_next;
                fnd_next = seen_next;
                ov_next  = 1'b1;
                if (acc_next && seen_next)
                begin
                    lease_srv_next = srv_sh_next;
                    lease_off_next = off_sh_next;
                end
                phase_next  = PH_CODE;
                match_next  = 1'b1;
                typ_next    = 1'b0;
                skip_next   = '0;
                cap_next    = '0;
                srv_sh_next = '0;
                off_sh_next = '0;
                seen_next   = 1'b0;
                done_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CODE;
            match_reg     <= 1'b1;
            typ_reg       <= 1'b0;
            skip_reg      <= '0;
            cap_reg       <= '0;
            srv_sh_reg    <= '0;
            off_sh_reg    <= '0;
            seen_reg      <= 1'b0;
            done_reg      <= 1'b0;
            lease_srv_reg <= '0;
            lease_off_reg <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            match_reg     <= match_next;
            typ_reg       <= typ_next;
            skip_reg      <= skip_next;
            cap_reg       <= cap_next;
            srv_sh_reg    <= srv_sh_next;
            off_sh_reg    <= off_sh_next;
            seen_reg      <= seen_next;
            done_reg      <= done_next;
            lease_srv_reg <= lease_srv_next;
            lease_off_reg <= lease_off_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        fnd_reg <= fnd_next;
    end

    assign out_valid    = ov_reg;
    assign accepted     = acc_reg;
    assign server_found = fnd_reg;
    assign server_addr  = lease_srv_reg;
    assign offered_addr = lease_off_reg;

    a_seen_done: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> done_reg)
        else $error("server id seen without walk done");

    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg <= 3'd5)
        else $error("capture count out of range");

    a_cap_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_CAPTURE |-> cap_reg == 3'd0)
        else $error("capture count set outside capture");

    a_skip_code: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CODE |-> skip_reg == 8'd0)
        else $error("skip count left over at option code");

endmodule

// ----- hw/rtl/dhcp_reply_filter_extract.sv -----
// ----------------------------------------------------------------------------
// dhcp_reply_filter_extract
// DHCP reply filter: checks op, client MAC, cookie and message type, and keeps
// the server identifier and offered address of accepted frames that have one.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle in wire order, with no gap needed between
// bytes or frames. A front stage tags each byte with its BOOTP field and pushes
// it into a four-entry queue; a back stage checks the tags and walks the
// options, one byte per cycle while no earlier result is left untaken. One
// result transaction is produced per frame at its last byte: out_valid is
// registered and rises when the back stage pops that byte, after any bytes
// still queued ahead of it. Input stalls only when the queue fills behind a
// result that the output side has not yet taken. Configuration is written
// through cfg_*, index 0 own_mac, index 1 expected_type, always ready; write
// it only while no frame is in flight.
// ----------------------------------------------------------------------------
module dhcp_reply_filter_extract
    import drfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           frame_byte,
    input  logic                 frame_end,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 accepted,
    output logic                 server_found,
    output logic [31:0]          server_addr,
    output logic [31:0]          offered_addr,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]          cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic q_push;
    ent_t q_in;
    logic q_full;
    logic q_pop;
    logic q_valid;
    ent_t q_head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OWN_MAC:       cfg_next.own_mac       = cfg_data;
                REG_EXPECTED_TYPE: cfg_next.expected_type = cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{own_mac: 48'd0, expected_type: 4'd2};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    drfe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_ent      (q_in)
    );

    drfe_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_ent (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    drfe_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .server_found (server_found),
        .server_addr  (server_addr),
        .offered_addr (offered_addr)
    );

endmodule
